FILE: hw/rtl/positional_list_engine_macros.svh
// assertion macros for the positional list engine
// each macro expects clk and rst in scope of the module that uses it
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// property that holds at every edge outside reset
`define PLE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ple check failed");

// same-cycle implication
`define PLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ple check failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ple check failed");

`endif

FILE: hw/rtl/ple_pkg.sv
// shared types and codes for the positional list engine
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL,
    CMD_READ,
    CMD_FIND
  } cell_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         length;
    logic                     empty_res;
  } res_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ple_cell.sv
// one storage cell of the list chain: holds one entry and a match flag
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ple_pkg::cell_ctl_t               ctl,
  input  logic [IW-1:0]                    idx,
  input  logic [CW-1:0]                    cnt,
  input  logic signed [ple_pkg::DATA_W-1:0] prev_entry,
  input  logic signed [ple_pkg::DATA_W-1:0] next_entry,
  output logic signed [ple_pkg::DATA_W-1:0] entry,
  output logic                             hit
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] entry_next;
  logic                     hit_next;
  logic                     at_idx;
  logic                     past_idx;
  logic                     in_list;

  always_comb begin
    at_idx     = (IW'(IDX) == idx);
    past_idx   = (IW'(IDX) > idx);
    in_list    = (CW'(IDX) < cnt);
    entry_next = entry;
    // flag holds while no word is taken, so a stalled result still sees it
    hit_next   = (ctl.cmd == CMD_NONE) ? hit : 1'b0;
    case (ctl.cmd)
      CMD_INS: begin
        if (at_idx) begin
          entry_next = ctl.value;
        end else if (past_idx) begin
          entry_next = prev_entry;
        end
      end
      CMD_DEL: begin
        if (at_idx || past_idx) begin
          entry_next = next_entry;
        end
      end
      CMD_READ: hit_next = at_idx;
      CMD_FIND: hit_next = in_list && (entry == ctl.value);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

FILE: hw/rtl/ple_reduce.sv
// gathers the registered cell match flags: first match position and read word
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_reduce #(
  parameter int N = 64
) (
  input  logic [N-1:0]                      hit,
  input  logic signed [ple_pkg::DATA_W-1:0] vals [N],
  output logic                              any,
  output logic [ple_pkg::POS_W-1:0]         first_pos,
  output logic signed [ple_pkg::DATA_W-1:0] hit_val
);
  import ple_pkg::*;

  logic [N-1:0] first;

  always_comb begin
    // lowest set bit only
    first     = hit & (~hit + N'(1));
    first_pos = '0;
    hit_val   = '0;
    for (int k = 0; k < N; k++) begin
      if (first[k]) begin
        first_pos = first_pos | POS_W'(k + 1);
      end
      if (hit[k]) begin
        hit_val = hit_val | vals[k];
      end
    end
    any = |hit;
  end

endmodule

FILE: hw/rtl/positional_list_engine.sv
// Positional list engine. Keeps an ordered list of up to CAPACITY signed 32-bit
// entries in a chain of cells; insert and delete shift every cell behind the
// position by one place at the accepting edge, and locate compares all cells at
// once. One word is taken per clock while req_ready is high; its result is
// registered via the cell update and match flags at the accepting edge, then
// the gather of the flags into the result register as the chain stage moves on.
// Results are one per word, in order; a waiting result holds the chain stage and
// stalls the request side only once both are full. Length and found position are
// reported in 7 bits. Depends on ple_pkg, ple_cell, ple_reduce and the macros.
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ple_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ple_pkg::res_t res
);
  import ple_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W ? CW : POS_W) + 1;

  logic                     req_fire;
  logic                     a_move;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [PW-1:0]            pos_w;
  logic [PW-1:0]            cnt_w;
  logic                     pos_zero;
  logic [IW-1:0]            idx;
  cell_ctl_t                ctl;
  logic [STAT_W-1:0]        st;
  logic                     is_find;
  logic                     is_read;

  // chain stage registers
  logic                     a_vld;
  logic [STAT_W-1:0]        a_status;
  logic [POS_W-1:0]         a_len;
  logic                     a_empty;
  logic                     a_find;
  logic                     a_read;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]      hit;
  logic                     any;
  logic [POS_W-1:0]         first_pos;
  logic signed [DATA_W-1:0] hit_val;

  logic                     o_vld;
  res_t                     res_q;
  res_t                     res_next;

  assign a_move    = a_vld && (!o_vld || res_ready);
  assign req_ready = !a_vld || a_move;
  assign req_fire  = req_valid && req_ready;
  assign res_valid = o_vld;
  assign res       = res_q;

  always_comb begin
    pos_w      = PW'(req.position);
    cnt_w      = PW'(count);
    pos_zero   = (req.position == '0);
    idx        = IW'(req.position - POS_W'(1));
    ctl.cmd    = CMD_NONE;
    ctl.value  = req.value;
    st         = ST_DONE;
    count_next = count;
    is_find    = 1'b0;
    is_read    = 1'b0;
    if (req_fire) begin
      case (req.mode)
        MODE_INSERT: begin
          if (pos_zero || pos_w > cnt_w + PW'(1)) begin
            st = ST_RANGE;
          end else if (count == CW'(CAPACITY)) begin
            st = ST_FULL;
          end else begin
            ctl.cmd    = CMD_INS;
            count_next = count + CW'(1);
          end
        end
        MODE_DELETE: begin
          if (pos_zero || pos_w > cnt_w) begin
            st = ST_RANGE;
          end else begin
            ctl.cmd    = CMD_DEL;
            count_next = count - CW'(1);
          end
        end
        MODE_READ: begin
          if (pos_zero || pos_w > cnt_w) begin
            st = ST_RANGE;
          end else begin
            ctl.cmd = CMD_READ;
            is_read = 1'b1;
          end
        end
        MODE_FIND: begin
          ctl.cmd = CMD_FIND;
          is_find = 1'b1;
        end
        MODE_CLEAR: count_next = '0;
        default: ;
      endcase
    end
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] prev_e;
      logic signed [DATA_W-1:0] next_e;
      if (g == 0) begin : g_first
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = cell_q[g+1];
      end
      ple_cell #(
        .IDX(g),
        .IW (IW),
        .CW (CW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .idx       (idx),
        .cnt       (count),
        .prev_entry(prev_e),
        .next_entry(next_e),
        .entry     (cell_q[g]),
        .hit       (hit[g])
      );
    end
  endgenerate

  ple_reduce #(
    .N(CAPACITY)
  ) u_reduce (
    .hit      (hit),
    .vals     (cell_q),
    .any      (any),
    .first_pos(first_pos),
    .hit_val  (hit_val)
  );

  always_comb begin
    res_next.status         = (a_find && !any) ? ST_NOTFOUND : a_status;
    res_next.read_value     = a_read ? hit_val : '0;
    res_next.found_position = (a_find && any) ? first_pos : '0;
    res_next.length         = a_len;
    res_next.empty_res      = a_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      a_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      count <= count_next;
      if (req_fire) begin
        a_vld <= 1'b1;
      end else if (a_move) begin
        a_vld <= 1'b0;
      end
      if (a_move) begin
        o_vld <= 1'b1;
      end else if (res_ready) begin
        o_vld <= 1'b0;
      end
    end
    if (req_fire) begin
      a_status <= st;
      a_len    <= POS_W'(count_next);
      a_empty  <= (count_next == '0);
      a_find   <= is_find;
      a_read   <= is_read;
    end
    if (a_move) begin
      res_q <= res_next;
    end
  end

  `PLE_ASSERT_ALWAYS(a_count_cap, count <= CW'(CAPACITY))
  `PLE_ASSERT_IMPL(a_read_onehot, a_vld && a_read, $onehot(hit))
  `PLE_ASSERT_NEXT(a_ins_grows, !rst && ctl.cmd == CMD_INS, count == $past(count) + CW'(1))
  `PLE_ASSERT_NEXT(a_del_shrinks, !rst && ctl.cmd == CMD_DEL, count == $past(count) - CW'(1))
  `PLE_ASSERT_NEXT(a_stage_holds, a_vld && !a_move, a_vld && $stable(a_status))

endmodule
